[sv/rc6enc_pkg.sv]
// rc6enc_pkg: shared types and constants for the RC6 mode-0 frame encoder.
// Holds the run item passed from the front sequencer to the back merger.
// No dependencies.
package rc6enc_pkg;

  localparam int DurW  = 20;   // segment duration width in samples
  localparam int HbsW  = 16;   // half-bit length register width
  localparam int UnitW = 4;    // run length in half-bit units, merged max 11
  localparam int StepW = 6;    // front sequencer step counter

  // front sequencer steps: 46 raw runs per frame
  localparam logic [StepW-1:0] StepGap      = 6'd0;
  localparam logic [StepW-1:0] StepMark     = 6'd1;
  localparam logic [StepW-1:0] StepSpace    = 6'd2;
  localparam logic [StepW-1:0] StepHdrFirst = 6'd3;   // start bit + 3 mode bits
  localparam logic [StepW-1:0] StepHdrLast  = 6'd10;
  localparam logic [StepW-1:0] StepTogLow   = 6'd11;
  localparam logic [StepW-1:0] StepTogHigh  = 6'd12;
  localparam logic [StepW-1:0] StepDatFirst = 6'd13;  // address then data, MSB first
  localparam logic [StepW-1:0] StepDatLast  = 6'd44;
  localparam logic [StepW-1:0] StepPad      = 6'd45;

  localparam logic [UnitW-1:0] UnitsGap    = 4'd10;
  localparam logic [UnitW-1:0] UnitsMark   = 4'd6;
  localparam logic [UnitW-1:0] UnitsDouble = 4'd2;
  localparam logic [UnitW-1:0] UnitsOne    = 4'd1;

  localparam logic [3:0] HdrBits = 4'b1000;  // start 1, mode 000 (index 3 sent first)

  localparam int QDepth = 4;
  localparam int QAw    = 2;

  typedef struct packed {
    logic             level;
    logic [UnitW-1:0] units;
    logic             last;
  } run_t;

endpackage

[sv/rc6enc_front.sv]
// rc6enc_front: accepts a frame item and walks it out as raw level runs.
// Depends on rc6enc_pkg. One run per cycle into the run queue while it is not full.
module rc6enc_front import rc6enc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] address,
  input  logic [7:0] payload,
  input  logic       push,
  output logic       full,
  output logic       run_valid,
  output run_t       run,
  input  logic       run_full
);

  logic             busy;
  logic [StepW-1:0] step;
  logic [15:0]      word;
  logic [StepW-1:0] hdr_off;
  logic [StepW-1:0] dat_off;
  logic [3:0]       dat_idx;
  logic             bitval;

  assign full      = busy;
  assign run_valid = busy;

  assign hdr_off = step - StepHdrFirst;
  assign dat_off = step - StepDatFirst;
  assign dat_idx = 4'd15 - dat_off[4:1];

  always_comb begin
    bitval    = 1'b0;
    run.level = 1'b0;
    run.units = UnitsOne;
    run.last  = 1'b0;
    case (step) inside
      StepGap: begin
        run.units = UnitsGap;
      end
      StepMark: begin
        run.level = 1'b1;
        run.units = UnitsMark;
      end
      StepSpace: begin
        run.units = UnitsDouble;
      end
      [StepHdrFirst:StepHdrLast]: begin
        bitval    = HdrBits[2'd3 - hdr_off[2:1]];
        run.level = bitval ^ hdr_off[0];   // 1 is high then low
      end
      StepTogLow: begin
        run.units = UnitsDouble;
      end
      StepTogHigh: begin
        run.level = 1'b1;
        run.units = UnitsDouble;
      end
      [StepDatFirst:StepDatLast]: begin
        bitval    = word[dat_idx];
        run.level = bitval ^ dat_off[0];
      end
      StepPad: begin
        run.units = UnitsGap;
        run.last  = 1'b1;
      end
      default: begin
        run.level = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= StepGap;
    end else if (!busy) begin
      if (push) begin
        busy <= 1'b1;
        step <= StepGap;
      end
    end else if (!run_full) begin
      if (step == StepPad) begin
        busy <= 1'b0;
      end
      step <= step + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && push) begin
      word <= {address, payload};
    end
  end

endmodule

[sv/rc6enc_fifo.sv]
// rc6enc_fifo: short run queue between front sequencer and back merger.
// Depends on rc6enc_pkg for run_t and queue depth.
module rc6enc_fifo import rc6enc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  run_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output run_t rd_data,
  output logic q_empty
);

  run_t           mem [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0]   count;
  logic           do_wr;
  logic           do_rd;

  assign q_full  = (count == (QAw+1)'(QDepth));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[sv/rc6enc_back.sv]
// rc6enc_back: merges equal-level runs, scales units to samples, holds result.
// Depends on rc6enc_pkg. Owns the output register and the half-bit multiply.
module rc6enc_back import rc6enc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [HbsW-1:0] half_bit_samples,
  input  run_t            run,
  input  logic            q_empty,
  output logic            rd_en,
  output logic            level,
  output logic [DurW-1:0] duration,
  output logic            last,
  output logic            empty,
  input  logic            pop
);

  logic             acc_valid;
  logic             acc_level;
  logic [UnitW-1:0] acc_units;
  logic             acc_end;
  logic             out_valid;
  logic             out_free;
  logic             same;
  logic             emit;
  logic [DurW-1:0]  dur_next;

  assign out_free = !out_valid || pop;
  assign same     = (run.level == acc_level);

  // take a run if the accumulator is empty, or holds no closing run and it merges or the old segment can leave
  assign rd_en = !q_empty &&
                 (!acc_valid || (!acc_end && (same || out_free)));

  // segment leaves on a level change or once the closing run is folded in
  assign emit = acc_valid && out_free &&
                (acc_end || (!q_empty && !same));

  assign dur_next = DurW'(acc_units * half_bit_samples);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
      acc_end   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        acc_valid <= 1'b1;
        acc_end   <= run.last;
      end else if (emit) begin
        acc_valid <= 1'b0;
        acc_end   <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      acc_level <= run.level;
      if (acc_valid && same) begin
        acc_units <= acc_units + run.units;
      end else begin
        acc_units <= run.units;
      end
    end
    if (emit) begin
      level    <= acc_level;
      duration <= dur_next;
      last     <= acc_end;
    end
  end

endmodule

[sv/rc6_mode0_frame_encoder_top.sv]
// rc6_mode0_frame_encoder_top: RC6 mode-0 frame encoder, top level.
// Depends on rc6enc_pkg, rc6enc_front, rc6enc_fifo, rc6enc_back.
//
// Push one item (address, payload) and the block returns the line waveform of
// one RC6 mode-0 frame as 29 to 45 result items, each a level and a duration
// in samples, with last set on the closing segment. The frame is a 10-unit
// low gap, a 6/2 leader, start bit 1, mode 000, a double-width toggle bit 0,
// address and payload MSB first (1 = high then low), and a 10-unit low pad;
// adjacent runs of equal level come out merged. half_bit_samples scales every
// unit and is written through cfg_valid/cfg_ready/cfg_data (ready is always
// high; write it only while no frame is in flight). The front walks the 46
// raw runs at one per cycle while the run queue has room; full stays high
// until the item's last run is queued, and only then is a new item taken. The
// back merges runs and emits at most one result per cycle; a 4-entry run
// queue and a one-deep output register let either side stall on its own.
module rc6_mode0_frame_encoder_top import rc6enc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  // configuration write channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [HbsW-1:0] cfg_data,
  // item input, queue style
  input  logic [7:0]      address,
  input  logic [7:0]      payload,
  input  logic            push,
  output logic            full,
  // result output, queue style
  output logic            level,
  output logic [DurW-1:0] duration,
  output logic            last,
  output logic            empty,
  input  logic            pop
);

  logic [HbsW-1:0] half_bit_samples;
  logic            front_valid;
  run_t            front_run;
  logic            q_full;
  logic            q_empty;
  logic            q_rd;
  run_t            q_run;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_samples <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      half_bit_samples <= cfg_data;
    end
  end

  // front: latch item, sequence raw runs
  rc6enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .address   (address),
    .payload   (payload),
    .push      (push),
    .full      (full),
    .run_valid (front_valid),
    .run       (front_run),
    .run_full  (q_full)
  );

  rc6enc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_run),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_data (q_run),
    .q_empty (q_empty)
  );

  // back: merge, scale, hold result
  rc6enc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .half_bit_samples (half_bit_samples),
    .run              (q_run),
    .q_empty          (q_empty),
    .rd_en            (q_rd),
    .level            (level),
    .duration         (duration),
    .last             (last),
    .empty            (empty),
    .pop              (pop)
  );

endmodule

[test/rc6_frame_checker.sv]
// rc6_frame_checker: watches the RC6 mode-0 encoder's channels, predicts each frame's segments
// and compares them with what the block emits. Depends on rc6enc_pkg for widths.
`timescale 1ns / 100ps

module rc6_frame_checker import rc6enc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [HbsW-1:0] cfg_data,
  input  logic [7:0]      address,
  input  logic [7:0]      payload,
  input  logic            push,
  input  logic            full,
  input  logic            level,
  input  logic [DurW-1:0] duration,
  input  logic            last,
  input  logic            empty,
  input  logic            pop,
  output int              fail_count,
  output int              busy_cnt
);

  localparam logic [HbsW-1:0] HalfBitReset = 16'd1000;
  localparam int GapUnits    = 10;
  localparam int MarkUnits   = 6;
  localparam int DoubleUnits = 2;
  localparam int MaxRuns     = 48;

  typedef struct packed {
    logic            level;
    logic [DurW-1:0] duration;
    logic            last;
  } seg_t;

  logic [HbsW-1:0] half_bit;
  seg_t            due_segs[$];
  logic            run_lvl[MaxRuns];
  int              run_units[MaxRuns];
  int              run_n;
  int              n_bad;

  initial begin
    fail_count = 0;
    busy_cnt   = 0;
    n_bad      = 0;
    half_bit   = HalfBitReset;
  end

  // equal levels merge into the previous run
  function automatic void add_run(input logic lvl, input int units);
    if (run_n > 0 && run_lvl[run_n-1] == lvl) begin
      run_units[run_n-1] += units;
    end else begin
      run_lvl[run_n]   = lvl;
      run_units[run_n] = units;
      run_n++;
    end
  endfunction

  // Manchester: 1 = high then low, 0 = low then high
  function automatic void add_bit(input logic b);
    add_run(b, 1);
    add_run(!b, 1);
  endfunction

  function automatic void expand_frame(input logic [7:0] addr, input logic [7:0] data);
    logic [15:0] bits;
    seg_t        s;
    int          i;
    int          k;
    bits  = {addr, data};
    run_n = 0;
    add_run(1'b0, GapUnits);
    add_run(1'b1, MarkUnits);
    add_run(1'b0, DoubleUnits);
    add_bit(1'b1);                       // start bit
    for (i = 0; i < 3; i++) add_bit(1'b0);   // mode 000
    add_run(1'b0, DoubleUnits);          // toggle 0, double width
    add_run(1'b1, DoubleUnits);
    for (i = 15; i >= 0; i--) add_bit(bits[i]);
    add_run(1'b0, GapUnits);
    for (k = 0; k < run_n; k++) begin
      s.level    = run_lvl[k];
      s.duration = DurW'(run_units[k] * half_bit);
      s.last     = (k == run_n - 1);
      due_segs.push_back(s);
    end
  endfunction

  always @(posedge clk) begin
    seg_t want;
    if (rst) begin
      half_bit = HalfBitReset;
      due_segs.delete();
    end else begin
      if (cfg_valid && cfg_ready) half_bit = cfg_data;
      if (!empty && pop) begin
        if (due_segs.size() == 0) begin
          n_bad++;
          $display("%0t: segment with none due: level %0b duration %0d last %0b",
                   $time, level, duration, last);
        end else begin
          want = due_segs.pop_front();
          if (want.level !== level || want.duration !== duration || want.last !== last) begin
            n_bad++;
            $display("%0t: segment mismatch: expected level %0b duration %0d last %0b,",
                     $time, want.level, want.duration, want.last);
            $display("%0t:   got level %0b duration %0d last %0b",
                     $time, level, duration, last);
          end
        end
      end
      if (push && !full) expand_frame(address, payload);
    end
    fail_count <= n_bad;
    busy_cnt   <= due_segs.size();
  end

endmodule

[test/tb_rc6_mode0_frame_encoder_top.sv]
// tb_rc6_mode0_frame_encoder_top: drives frame requests and half-bit settings into the
// RC6 mode-0 encoder and gives the verdict. Depends on rc6enc_pkg and rc6_frame_checker.
`timescale 1ns / 100ps

module tb_rc6_mode0_frame_encoder_top;
  import rc6enc_pkg::*;

  localparam int ItemsPerPhase = 70;
  localparam int RandPhases    = 6;

  // receiver behavior, switched when a random mode length runs out
  typedef enum int {PopAlways, PopCoin, PopPattern, PopSparse} pop_mode_e;

  logic            clk;
  logic            rst       = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [HbsW-1:0] cfg_data  = '0;
  logic [7:0]      address   = '0;
  logic [7:0]      payload   = '0;
  logic            push      = 1'b0;
  logic            full;
  logic            level;
  logic [DurW-1:0] duration;
  logic            last;
  logic            empty;
  logic            pop       = 1'b0;

  int              fail_count;
  int              busy_cnt;
  int              burst_left = 0;

  pop_mode_e       pop_mode   = PopAlways;
  int              mode_left  = 0;
  logic [7:0]      pop_pattern = 8'hA5;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  rc6_mode0_frame_encoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .address   (address),
    .payload   (payload),
    .push      (push),
    .full      (full),
    .level     (level),
    .duration  (duration),
    .last      (last),
    .empty     (empty),
    .pop       (pop)
  );

  rc6_frame_checker i_frame_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .address    (address),
    .payload    (payload),
    .push       (push),
    .full       (full),
    .level      (level),
    .duration   (duration),
    .last       (last),
    .empty      (empty),
    .pop        (pop),
    .fail_count (fail_count),
    .busy_cnt   (busy_cnt)
  );

  // Receiver: pop pattern of its own, independent of the sender. Mode
  // state is local to this block, only pop is a nonblocking drive.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode    = pop_mode_e'($urandom_range(0, 3));
        mode_left   = $urandom_range(20, 200);
        pop_pattern = 8'($urandom_range(1, 255));
      end else begin
        mode_left--;
      end
      case (pop_mode)
        PopAlways:  pop <= 1'b1;
        PopCoin:    pop <= 1'($urandom_range(0, 1));
        PopPattern: begin
          pop <= pop_pattern[0];
          pop_pattern = {pop_pattern[0], pop_pattern[7:1]};
        end
        default:    pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // One frame request. A new burst may open with a gap of random length;
  // push stays high across back-to-back items inside a burst.
  task automatic send_frame(input logic [7:0] a, input logic [7:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    address <= a;
    payload <= p;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
  endtask

  // Drop push and wait until every predicted segment has been popped.
  // Each frame ends on a segment, so a short tail is enough for the block
  // to be idle.
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (busy_cnt != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // half_bit_samples is only written with no frame in flight
  task automatic set_half_bit(input logic [HbsW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int ph;
    int n;
    logic [HbsW-1:0] hb;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset length, byte extremes, alternating bits (merge
    // patterns), a trailing 1 whose low half merges into the pad
    send_frame(8'h00, 8'h00);
    send_frame(8'hFF, 8'hFF);
    send_frame(8'h55, 8'hAA);
    send_frame(8'hAA, 8'h55);
    send_frame(8'h80, 8'h01);
    send_frame(8'h01, 8'h80);
    send_frame(8'hFF, 8'h00);
    send_frame(8'h00, 8'hFF);
    send_frame(8'hF0, 8'h0F);
    send_frame(8'h0F, 8'hF0);
    // largest unit length: longest durations
    set_half_bit(16'hFFFF);
    send_frame(8'hFF, 8'hFF);
    send_frame(8'h00, 8'h00);
    send_frame(8'h01, 8'hFE);
    // zero unit length: same segment shape, all durations zero
    set_half_bit(16'h0000);
    send_frame(8'h5A, 8'hA5);
    send_frame(8'hFF, 8'h01);
    // smallest legal unit length
    set_half_bit(16'h0001);
    send_frame(8'h00, 8'h00);
    send_frame(8'hFF, 8'hFF);
    send_frame(8'h81, 8'h18);

    // random frames over several unit lengths
    for (ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       hb = 16'($urandom_range(1, 65535));
        1:       hb = 16'($urandom_range(1, 40));
        2:       hb = 16'hFFFF;
        3:       hb = 16'h0001;
        4:       hb = 16'($urandom_range(2, 300));
        default: hb = 16'd1000;
      endcase
      set_half_bit(hb);
      for (n = 0; n < ItemsPerPhase; n++)
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && busy_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
